FILE: rtl/core/khrp_pkg.sv
// Shared types and constants of the keyed handle reuse pool.
package khrp_pkg;

  localparam int unsigned SLOTS    = 64;
  localparam int unsigned ADDR_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W    = $clog2(SLOTS + 1);
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned HANDLE_W = 32;

  typedef enum logic [1:0] {
    MODE_TAKE     = 2'd0,
    MODE_REGISTER = 2'd1,
    MODE_RELEASE  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    key;
    logic                busy;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic [1:0]          mode;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } cmd_t;

  typedef struct packed {
    logic                hit;
    logic                found;
    logic [HANDLE_W-1:0] handle_out;
    slot_t               wr_slot;
  } match_t;

endpackage

FILE: rtl/core/khrp_if.sv
// Handshake interfaces for the request and result words of the pool.
interface khrp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] key;
  logic [31:0] handle;

  modport source (output valid, output mode, output key, output handle, input ready);
  modport sink   (input valid, input mode, input key, input handle, output ready);
endinterface

interface khrp_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] handle_out;

  modport source (output valid, output found, output handle_out, input ready);
  modport sink   (input valid, input found, input handle_out, output ready);
endinterface

FILE: rtl/core/khrp_ram.sv
// Generic simple dual-port RAM with registered read.
module khrp_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/khrp_match.sv
// Per-slot match test and write-back value for take, register and release.
module khrp_match (
  input  khrp_pkg::cmd_t   cmd_i,
  input  khrp_pkg::slot_t  slot_i,
  output khrp_pkg::match_t match_o
);
  import khrp_pkg::*;

  always_comb begin
    match_o            = '0;
    match_o.wr_slot    = slot_i;
    case (cmd_i.mode)
      MODE_TAKE: begin
        match_o.hit          = (slot_i.handle != '0) && !slot_i.busy &&
                               (slot_i.key == cmd_i.key);
        match_o.found        = 1'b1;
        match_o.handle_out   = slot_i.handle;
        match_o.wr_slot.busy = 1'b1;
      end
      MODE_REGISTER: begin
        match_o.hit            = (slot_i.handle == '0);
        match_o.found          = 1'b1;
        match_o.wr_slot.handle = cmd_i.handle;
        match_o.wr_slot.key    = cmd_i.key;
        match_o.wr_slot.busy   = 1'b1;
      end
      MODE_RELEASE: begin
        match_o.hit = (slot_i.handle == cmd_i.handle);
        if (slot_i.key != '0) begin
          // keep in pool, mark idle
          match_o.found        = 1'b1;
          match_o.wr_slot.busy = 1'b0;
        end else begin
          // not reusable: clear slot
          match_o.found   = 1'b0;
          match_o.wr_slot = '0;
        end
      end
      default: begin
        match_o.hit = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/core/keyed_handle_reuse_pool_core.sv
// Top level of the keyed handle reuse pool: slot RAM, scan sequencer, result register.
// Flow: an accepted request scans the slots from slot 0 up to the first match, one slot
// read per cycle; an unused mode or a null handle on register/release skips the scan.
// One request in flight; the next word is taken in the cycle after the result is posted.
// Reset: asynchronous, active low; a clearing pass then zeroes every slot.
module keyed_handle_reuse_pool_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  khrp_in_if.sink     in_i,
  khrp_out_if.source  out_o
);
  import khrp_pkg::*;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;       // clear index or next read index
  logic                pend_q, pend_d;     // read data for pidx_q arrives this cycle
  logic [ADDR_W-1:0]   pidx_q, pidx_d;
  cmd_t                cmd_q, cmd_d;
  logic                res_found_q, res_found_d;
  logic [HANDLE_W-1:0] res_handle_q, res_handle_d;
  logic                out_valid_q, out_valid_d;
  logic                out_found_q, out_found_d;
  logic [HANDLE_W-1:0] out_handle_q, out_handle_d;

  logic                we;
  logic [ADDR_W-1:0]   waddr;
  slot_t               wdata;
  logic                re;
  logic [ADDR_W-1:0]   raddr;
  logic [SLOT_W-1:0]   rdata;
  slot_t               rd_slot;
  match_t              match;
  logic                in_fire;
  logic                trivial;

  assign rd_slot = slot_t'(rdata);

  khrp_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  khrp_match u_match (
    .cmd_i   (cmd_q),
    .slot_i  (rd_slot),
    .match_o (match)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // Requests that skip the scan: unused mode, or null handle on register/release.
  assign trivial = !((in_i.mode == MODE_TAKE) || (in_i.mode == MODE_REGISTER) ||
                     (in_i.mode == MODE_RELEASE)) ||
                   ((in_i.mode != MODE_TAKE) && (in_i.handle == '0));

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pend_d       = 1'b0;
    pidx_d       = pidx_q;
    cmd_d        = cmd_q;
    res_found_d  = res_found_q;
    res_handle_d = res_handle_q;
    out_valid_d  = out_valid_q;
    out_found_d  = out_found_q;
    out_handle_d = out_handle_q;
    we           = 1'b0;
    waddr        = pidx_q;
    wdata        = match.wr_slot;
    re           = 1'b0;
    raddr        = cnt_q[ADDR_W-1:0];

    // Drop the result word once the sink takes it.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        // Zero one slot per cycle after reset.
        we    = 1'b1;
        waddr = cnt_q[ADDR_W-1:0];
        wdata = '0;
        if (cnt_q == CNT_W'(SLOTS - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          cmd_d.mode   = in_i.mode;
          cmd_d.key    = in_i.key;
          cmd_d.handle = in_i.handle;
          cnt_d        = '0;
          res_found_d  = 1'b0;
          res_handle_d = '0;
          state_d      = trivial ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Issue the next read while the previous entry is checked.
        if (cnt_q != CNT_W'(SLOTS)) begin
          re     = 1'b1;
          pend_d = 1'b1;
          pidx_d = cnt_q[ADDR_W-1:0];
          cnt_d  = cnt_q + 1'b1;
        end
        if (pend_q && match.hit) begin
          // First match: write back and stop the scan.
          we           = 1'b1;
          res_found_d  = match.found;
          res_handle_d = (cmd_q.mode == MODE_TAKE) ? match.handle_out : '0;
          pend_d       = 1'b0;
          state_d      = ST_DONE;
        end else if (cnt_q == CNT_W'(SLOTS) && pend_q) begin
          // Last slot checked without a match.
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_d) begin
          out_valid_d  = 1'b1;
          out_found_d  = res_found_q;
          out_handle_d = res_handle_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q       <= pidx_d;
    cmd_q        <= cmd_d;
    res_found_q  <= res_found_d;
    res_handle_q <= res_handle_d;
    out_found_q  <= out_found_d;
    out_handle_q <= out_handle_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.found      = out_found_q;
  assign out_o.handle_out = out_handle_q;

endmodule
